// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define LPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Assertion that is checked at every clock edge, reset included.
`define LPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the line pixel stepper modules.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;

    // Item kind carried on the input tuser.
    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Drawing phase of the current line.
    typedef enum logic [2:0]
    {
        PH_IDLE = 3'd0,
        PH_VERT = 3'd1,
        PH_HORZ = 3'd2,
        PH_XRUN = 3'd3,
        PH_YRUN = 3'd4
    } phase_t;

    // Control of the item held in the input register.
    typedef struct packed
    {
        logic valid;
        op_t  op;
    } item_ctl_t;

    // Control of the result produced by the step unit.
    typedef struct packed
    {
        logic valid;
        logic last;
    } res_ctl_t;

endpackage

// File: rtl/lps_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_in_reg
// Input register that holds one accepted item until the step unit takes it.
// ----------------------------------------------------------------------------
module lps_in_reg
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  op_t                    s_op,
    input  logic [COORD_WIDTH-1:0] s_x_a,
    input  logic [COORD_WIDTH-1:0] s_y_a,
    input  logic [COORD_WIDTH-1:0] s_x_b,
    input  logic [COORD_WIDTH-1:0] s_y_b,
    input  logic [RGB_W-1:0]       s_rgb,
    input  logic                   advance,
    output item_ctl_t              ctl,
    output logic [COORD_WIDTH-1:0] x_a,
    output logic [COORD_WIDTH-1:0] y_a,
    output logic [COORD_WIDTH-1:0] x_b,
    output logic [COORD_WIDTH-1:0] y_b,
    output logic [RGB_W-1:0]       rgb
);

    logic                   valid_reg;
    logic                   valid_next;
    op_t                    op_reg;
    logic [COORD_WIDTH-1:0] x_a_reg;
    logic [COORD_WIDTH-1:0] y_a_reg;
    logic [COORD_WIDTH-1:0] x_b_reg;
    logic [COORD_WIDTH-1:0] y_b_reg;
    logic [RGB_W-1:0]       rgb_reg;
    logic                   take;

    // The register is free when empty or when its item moves on this cycle.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= s_op;
            x_a_reg <= s_x_a;
            y_a_reg <= s_y_a;
            x_b_reg <= s_x_b;
            y_b_reg <= s_y_b;
            rgb_reg <= s_rgb;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.op    = op_reg;
    assign x_a       = x_a_reg;
    assign y_a       = y_a_reg;
    assign x_b       = x_b_reg;
    assign y_b       = y_b_reg;
    assign rgb       = rgb_reg;

endmodule

// File: rtl/lps_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_step
// Line state and the combinational step logic that produces the next pixel.
// ----------------------------------------------------------------------------
module lps_step
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  item_ctl_t              ctl,
    input  logic                   advance,
    input  logic [COORD_WIDTH-1:0] x_a,
    input  logic [COORD_WIDTH-1:0] y_a,
    input  logic [COORD_WIDTH-1:0] x_b,
    input  logic [COORD_WIDTH-1:0] y_b,
    input  logic [RGB_W-1:0]       rgb,
    output res_ctl_t               res,
    output logic [COORD_WIDTH-1:0] pixel_x,
    output logic [COORD_WIDTH-1:0] pixel_y,
    output logic [RGB_W-1:0]       pixel_rgb
);

    localparam int W  = COORD_WIDTH;
    // The error term is (cx - ox) * dy - (cy - oy) * dx, kept incrementally.
    localparam int EW = 2 * COORD_WIDTH + 3;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [W-1:0]          cx_reg;
    logic [W-1:0]          cx_next;
    logic [W-1:0]          cy_reg;
    logic [W-1:0]          cy_next;
    logic [W-1:0]          tx_reg;
    logic [W-1:0]          tx_next;
    logic [W-1:0]          ty_reg;
    logic [W-1:0]          ty_next;
    logic [W-1:0]          dx_reg;
    logic [W-1:0]          dx_next;
    logic [W:0]            dy_reg;
    logic [W:0]            dy_next;
    logic signed [EW-1:0]  err_reg;
    logic signed [EW-1:0]  err_next;
    logic [RGB_W-1:0]      rgb_reg;
    logic [RGB_W-1:0]      rgb_next;

    logic                  swap;
    logic [W-1:0]          lx;
    logic [W-1:0]          ly;
    logic [W-1:0]          rx;
    logic [W-1:0]          ry;
    logic [W-1:0]          dx_new;
    logic [W:0]            dy_new;
    logic                  up;
    logic                  active;
    logic                  last;
    logic                  stay;
    logic                  more;
    logic [W:0]            cx_inc;
    logic [W:0]            cy_inc;
    logic [W-1:0]          cy_dec;
    logic signed [EW-1:0]  dy_e;
    logic signed [EW-1:0]  dx_e;
    logic signed [EW-1:0]  dxw_e;
    logic signed [EW-1:0]  err_x;
    logic signed [EW-1:0]  err_yu;
    logic signed [EW-1:0]  err_yd;

    // Endpoint ordering for a start item: x never falls along the line.
    assign swap   = x_b < x_a;
    assign lx     = swap ? x_b : x_a;
    assign ly     = swap ? y_b : y_a;
    assign rx     = swap ? x_a : x_b;
    assign ry     = swap ? y_a : y_b;
    assign dx_new = rx - lx;
    assign dy_new = {1'b0, ry} - {1'b0, ly};

    assign up     = !dy_reg[W] && (dy_reg != '0);
    assign cx_inc = {1'b0, cx_reg} + {{W{1'b0}}, 1'b1};
    assign cy_inc = {1'b0, cy_reg} + {{W{1'b0}}, 1'b1};
    assign cy_dec = cy_reg - {{(W-1){1'b0}}, 1'b1};

    assign dy_e   = {{(EW-W-1){dy_reg[W]}}, dy_reg};
    assign dx_e   = {{(EW-W){1'b0}}, dx_reg};
    assign dxw_e  = {{(EW-2*W){1'b0}}, dx_reg, {W{1'b0}}};
    assign err_x  = err_reg + dy_e;
    assign err_yu = err_reg - dx_e;
    assign err_yd = err_reg + dx_e;

    always_comb
    begin
        active = 1'b0;
        case (phase_reg)
            PH_VERT, PH_HORZ, PH_XRUN, PH_YRUN: active = 1'b1;
            default:                            active = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        err_next   = err_reg;
        rgb_next   = rgb_reg;
        last       = 1'b0;
        stay       = 1'b0;
        more       = 1'b0;

        if (ctl.op == OP_START)
        begin
            cx_next  = lx;
            cy_next  = ly;
            tx_next  = rx;
            ty_next  = ry;
            dx_next  = dx_new;
            dy_next  = dy_new;
            err_next = '0;
            rgb_next = rgb;
            if (dx_new == '0)
            begin
                phase_next = PH_VERT;
            end
            else if (dy_new == '0)
            begin
                phase_next = PH_HORZ;
            end
            else
            begin
                phase_next = PH_XRUN;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_VERT:
                begin
                    if (cy_reg == ty_reg)
                    begin
                        last = 1'b1;
                    end
                    else if (cy_reg < ty_reg)
                    begin
                        cy_next = cy_inc[W-1:0];
                    end
                    else
                    begin
                        cy_next = cy_dec;
                    end
                end
                PH_HORZ:
                begin
                    if (cx_reg >= tx_reg)
                    begin
                        last = 1'b1;
                    end
                    else
                    begin
                        cx_next = cx_inc[W-1:0];
                    end
                end
                PH_XRUN:
                begin
                    cx_next  = cx_inc[W-1:0];
                    err_next = err_x;
                    if (up)
                    begin
                        stay = err_x[EW-1];
                    end
                    else
                    begin
                        stay = !err_x[EW-1] && (err_x != '0);
                    end
                    if (!(stay && (cx_inc < {1'b0, tx_reg})))
                    begin
                        phase_next = PH_YRUN;
                    end
                end
                PH_YRUN:
                begin
                    if (up)
                    begin
                        cy_next = cy_inc[W-1:0];
                        more    = !err_yu[EW-1] && (err_yu != '0)
                                  && (cy_inc < {1'b0, ty_reg});
                        // Stepping past the top edge wraps the cursor to zero.
                        err_next = cy_inc[W] ? (err_yu + dxw_e) : err_yu;
                    end
                    else if (cy_reg == '0)
                    begin
                        // Stepping below zero wraps to the top row and the run goes on.
                        cy_next  = cy_dec;
                        more     = 1'b1;
                        err_next = err_yd - dxw_e;
                    end
                    else
                    begin
                        cy_next  = cy_dec;
                        more     = err_yd[EW-1] && (cy_dec > ty_reg);
                        err_next = err_yd;
                    end
                    if (!more)
                    begin
                        if (cx_reg < tx_reg)
                        begin
                            phase_next = PH_XRUN;
                        end
                        else
                        begin
                            last = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (last)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            err_reg <= err_next;
            rgb_reg <= rgb_next;
        end
    end

    assign res.valid = ctl.valid && (ctl.op == OP_STEP) && active;
    assign res.last  = last;
    assign pixel_x   = cx_reg;
    assign pixel_y   = cy_reg;
    assign pixel_rgb = rgb_reg;

endmodule

// File: rtl/lps_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_out_reg
// Output register that holds one pixel until the receiver takes it.
// ----------------------------------------------------------------------------
module lps_out_reg
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  res_ctl_t               res,
    input  logic                   advance,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,
    input  logic [RGB_W-1:0]       pixel_rgb,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [RGB_W-1:0]       out_rgb,
    output logic                   m_tlast
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [COORD_WIDTH-1:0] x_reg;
    logic [COORD_WIDTH-1:0] y_reg;
    logic [RGB_W-1:0]       rgb_reg;
    logic                   last_reg;
    logic                   load;

    assign can_load = !valid_reg || m_tready;
    assign load     = advance && res.valid;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= pixel_x;
            y_reg    <= pixel_y;
            rgb_reg  <= pixel_rgb;
            last_reg <= res.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_rgb  = rgb_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/line_pixel_stepper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_stepper_top
// Line rasterizer that emits one pixel of the current line per step item.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries commands. tuser selects the kind: a start
// transfer loads two endpoints and a colour and produces no pixel, a step
// transfer produces the next pixel of the line on the master stream, with
// tlast marking the final pixel. A step while no line is active produces
// nothing. A start during a line abandons it and begins the new one.
// An input transfer reaches the master side through the input register, where
// the step unit works on the item, and then the output register, which
// captures its pixel. Throughput is one item per cycle while the receiver does
// not stall, set by the step unit, which updates the line state and an exact
// incremental slope error term with one add and compare per item.
// Reset clears the valid flags and returns the line to idle, so no pixel is
// pending after reset. When the receiver stalls, the pending pixel holds in
// the output register; the input register still takes one more item, and
// start items and idle steps keep flowing because they produce no pixel.
// ----------------------------------------------------------------------------
module line_pixel_stepper_top
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0 up: x_a, y_a, x_b, y_b, red, green, blue, zero pad.
    input  logic [((4*COORD_WIDTH+24+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0 up: operation (0 start, 1 step).
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, pixel_red, pixel_green,
    // pixel_blue, zero pad.
    output logic [((2*COORD_WIDTH+24+7)/8)*8-1:0] m_tdata,
    // Set on the last pixel of a line.
    output logic                      m_tlast
);

    localparam int W        = COORD_WIDTH;
    localparam int M_DATA_W = ((2*COORD_WIDTH+24+7)/8)*8;

    item_ctl_t              item_ctl;
    res_ctl_t               res_ctl;
    logic                   advance;
    logic                   can_load;
    op_t                    s_op;
    logic [RGB_W-1:0]       s_rgb;
    logic [W-1:0]           x_a;
    logic [W-1:0]           y_a;
    logic [W-1:0]           x_b;
    logic [W-1:0]           y_b;
    logic [RGB_W-1:0]       rgb;
    logic [W-1:0]           pixel_x;
    logic [W-1:0]           pixel_y;
    logic [RGB_W-1:0]       pixel_rgb;
    logic [W-1:0]           out_x;
    logic [W-1:0]           out_y;
    logic [RGB_W-1:0]       out_rgb;

    assign s_op  = op_t'(s_tuser);
    // Colour is kept red high, blue low.
    assign s_rgb = {s_tdata[4*W +: COLOR_W],
                    s_tdata[4*W+COLOR_W +: COLOR_W],
                    s_tdata[4*W+2*COLOR_W +: COLOR_W]};

    // The held item moves on when it makes no pixel or the output can take one.
    assign advance = item_ctl.valid && (!res_ctl.valid || can_load);

    lps_in_reg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_op),
        .s_x_a    (s_tdata[0 +: W]),
        .s_y_a    (s_tdata[W +: W]),
        .s_x_b    (s_tdata[2*W +: W]),
        .s_y_b    (s_tdata[3*W +: W]),
        .s_rgb    (s_rgb),
        .advance  (advance),
        .ctl      (item_ctl),
        .x_a      (x_a),
        .y_a      (y_a),
        .x_b      (x_b),
        .y_b      (y_b),
        .rgb      (rgb)
    );

    lps_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (item_ctl),
        .advance   (advance),
        .x_a       (x_a),
        .y_a       (y_a),
        .x_b       (x_b),
        .y_b       (y_b),
        .rgb       (rgb),
        .res       (res_ctl),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pixel_rgb (pixel_rgb)
    );

    lps_out_reg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res_ctl),
        .advance   (advance),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pixel_rgb (pixel_rgb),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_rgb   (out_rgb),
        .m_tlast   (m_tlast)
    );

    // Output order from bit 0: x, y, red, green, blue.
    assign m_tdata = M_DATA_W'({out_rgb[0 +: COLOR_W],
                                out_rgb[COLOR_W +: COLOR_W],
                                out_rgb[2*COLOR_W +: COLOR_W],
                                out_y,
                                out_x});

endmodule

// File: rtl/lps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks of the line pixel stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lps_checker
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [((2*COORD_WIDTH+24+7)/8)*8-1:0] m_tdata,
    input  logic                      m_tlast
);

    // A stalled pixel keeps its value until it is taken.
    `LPS_ASSERT(a_out_hold, clk, rst_n,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

    // With no pixel pending the block always takes input.
    `LPS_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_tvalid |-> s_tready)

    // Once reset has been seen at a clock edge, no pixel is pending in the next cycle.
    `LPS_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !m_tvalid)

    // A new pixel follows a step transfer taken earlier.
    `LPS_ASSERT(a_pixel_from_step, clk, rst_n,
        $rose(m_tvalid) |-> ($past(s_tvalid && s_tready, 2) && ($past(s_tuser, 2) == OP_STEP)))

endmodule

bind line_pixel_stepper_top lps_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
